// ===== design/dgrc_pkg.sv =====
`default_nettype none

package dgrc_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned NI_W = 5;
  localparam int unsigned ST_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_NODE = 2'd1,
    OP_ADD_EDGE = 2'd2,
    OP_VALIDATE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_EDGES_FULL = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_INVALID    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POP,
    S_LOAD,
    S_CNT,
    S_EDGE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    latch_in;
    logic    do_clear;
    logic    do_add_node;
    logic    do_edge_write;
    logic    ek_clr;
    logic    ek_inc;
    logic    walk_sel;
    logic    walk_init;
    logic    q_pop;
    logic    cur_load;
    logic    walk_visit;
    logic    path_we;
    logic    path_val;
    logic    res_load;
    status_e res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic node_full;
    logic bad_index;
    logic list_full;
    logic ec_zero;
    logic scan_hit;
    logic scan_last;
    logic no_nodes;
    logic q_empty;
    logic t_bad;
    logic all_reached;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/dgrc_dp.sv =====
`default_nettype none

module dgrc_dp #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned MAX_EDGES = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [dgrc_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [dgrc_pkg::NI_W-1:0]      source_node_i,
  input  wire logic [dgrc_pkg::NI_W-1:0]      target_node_i,
  input  wire dgrc_pkg::dp_cmd_t              cmd_i,
  output dgrc_pkg::dp_sts_t                   sts_o,
  output logic      [dgrc_pkg::ST_W-1:0]      status_o,
  output logic      [dgrc_pkg::NI_W-1:0]      node_index_o,
  output logic                                graph_valid_o
);
  import dgrc_pkg::*;

  localparam int unsigned NC_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned QI_W     = $clog2(MAX_NODES);
  localparam int unsigned EC_W     = $clog2(MAX_EDGES + 1);
  localparam int unsigned ET_DEPTH = MAX_NODES * MAX_EDGES;
  localparam int unsigned EA_W     = $clog2(ET_DEPTH);

  function automatic logic [EA_W-1:0] edge_addr(input logic [NI_W-1:0] node,
                                                input logic [EC_W-1:0] k);
    edge_addr = EA_W'(32'(node) * MAX_EDGES + 32'(k));
  endfunction

  // latched request
  logic [OP_W-1:0] op_q;
  logic [NI_W-1:0] src_q, dst_q;

  logic [NC_W-1:0]    nc_q;
  logic [EC_W-1:0]    ec_q [MAX_NODES];
  logic               path_q;
  logic [MAX_NODES-1:0] visited_q;
  logic [NC_W-1:0]    head_q, tail_q;
  logic [NI_W-1:0]    cur_q;
  logic [EC_W-1:0]    ek_q, ek_d;
  status_e            res_status_q;
  logic [NI_W-1:0]    res_index_q;
  logic [ST_W-1:0]    status_q;
  logic [NI_W-1:0]    node_index_q;
  logic               graph_valid_q;

  logic [NI_W-1:0] et_mem [ET_DEPTH];
  logic [NI_W-1:0] et_rd_q;
  logic [NI_W-1:0] q_mem [MAX_NODES];
  logic [NI_W-1:0] q_rd_q;

  logic [QI_W-1:0] ec_idx;
  logic [EC_W-1:0] ec_rd;
  logic [NI_W-1:0] sel_node;
  logic [EA_W-1:0] et_raddr, et_waddr;
  logic [QI_W-1:0] t_idx;
  logic            visit_new;
  logic            q_we;
  logic [QI_W-1:0] q_waddr;
  logic [NI_W-1:0] q_wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= opcode_i;
      src_q <= source_node_i;
      dst_q <= target_node_i;
    end
  end

  assign sel_node = cmd_i.walk_sel ? cur_q : src_q;
  assign ec_idx   = QI_W'(sel_node);
  assign ec_rd    = ec_q[ec_idx];

  always_comb begin
    ek_d = ek_q;
    if (cmd_i.ek_clr) begin
      ek_d = '0;
    end else if (cmd_i.ek_inc) begin
      ek_d = ek_q + EC_W'(1);
    end
  end

  // read runs one slot ahead: et_rd_q matches ek_q
  assign et_raddr = edge_addr(sel_node, ek_d);
  assign et_waddr = edge_addr(src_q, ec_rd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_edge_write) begin
      et_mem[et_waddr] <= dst_q;
    end
    et_rd_q <= et_mem[et_raddr];
  end

  assign t_idx     = QI_W'(et_rd_q);
  assign visit_new = !visited_q[t_idx] && (tail_q < NC_W'(MAX_NODES));
  assign q_we      = cmd_i.walk_init || (cmd_i.walk_visit && visit_new);
  assign q_waddr   = cmd_i.walk_init ? '0 : tail_q[QI_W-1:0];
  assign q_wdata   = cmd_i.walk_init ? '0 : et_rd_q;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_q <= q_mem[head_q[QI_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q      <= '0;
      path_q    <= 1'b0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      ek_q      <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        ec_q[i] <= '0;
      end
    end else begin
      ek_q <= ek_d;
      if (cmd_i.do_clear) begin
        nc_q   <= '0;
        path_q <= 1'b0;
        for (int i = 0; i < MAX_NODES; i++) begin
          ec_q[i] <= '0;
        end
      end else if (cmd_i.do_add_node) begin
        ec_q[nc_q[QI_W-1:0]] <= '0;
        nc_q                 <= nc_q + NC_W'(1);
      end else if (cmd_i.do_edge_write) begin
        ec_q[ec_idx] <= ec_rd + EC_W'(1);
      end
      if (cmd_i.path_we) begin
        path_q <= cmd_i.path_val;
      end
      if (cmd_i.walk_init) begin
        visited_q <= MAX_NODES'(1);
        head_q    <= '0;
        tail_q    <= NC_W'(1);
      end else begin
        if (cmd_i.q_pop) begin
          head_q <= head_q + NC_W'(1);
        end
        if (cmd_i.walk_visit && visit_new) begin
          visited_q[t_idx] <= 1'b1;
          tail_q           <= tail_q + NC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_q <= q_rd_q;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_index_q  <= cmd_i.do_add_node ? NI_W'(nc_q) : '0;
    end
    if (cmd_i.out_load) begin
      status_q      <= res_status_q;
      node_index_q  <= res_index_q;
      graph_valid_q <= path_q;
    end
  end

  assign status_o      = status_q;
  assign node_index_o  = node_index_q;
  assign graph_valid_o = graph_valid_q;

  always_comb begin
    sts_o.op          = op_e'(op_q);
    sts_o.node_full   = nc_q == NC_W'(MAX_NODES);
    sts_o.bad_index   = (32'(src_q) >= 32'(nc_q)) || (32'(dst_q) >= 32'(nc_q));
    sts_o.list_full   = ec_rd == EC_W'(MAX_EDGES);
    sts_o.ec_zero     = ec_rd == '0;
    sts_o.scan_hit    = et_rd_q == dst_q;
    sts_o.scan_last   = (ek_q + EC_W'(1)) == ec_rd;
    sts_o.no_nodes    = nc_q == '0;
    sts_o.q_empty     = head_q == tail_q;
    sts_o.t_bad       = 32'(et_rd_q) >= 32'(nc_q);
    sts_o.all_reached = tail_q == nc_q;
  end

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q <= NC_W'(MAX_NODES)) && (nc_q <= NC_W'(MAX_NODES)))
    else $error("node or queue count beyond capacity");

  a_edge_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_edge_write |-> (ec_rd < EC_W'(MAX_EDGES)) && !sts_o.bad_index)
    else $error("edge written into full or invalid list");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_clear |=> (nc_q == '0) && !path_q)
    else $error("clear left state behind");

  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_init |=> (head_q == '0) && (tail_q == NC_W'(1)) && visited_q[0])
    else $error("walk did not start from node zero");

endmodule

`default_nettype wire

// ===== design/dgrc_ctrl.sv =====
`default_nettype none

module dgrc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire dgrc_pkg::dp_sts_t sts_i,
  output dgrc_pkg::dp_cmd_t      cmd_o
);
  import dgrc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_ADD_EDGE: begin
            if (!sts_i.bad_index && !sts_i.list_full && !sts_i.ec_zero) begin
              state_d = S_SCAN;
            end else begin
              state_d = S_DONE;
            end
          end
          OP_VALIDATE: state_d = sts_i.no_nodes ? S_DONE : S_POP;
          default:     state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_last) state_d = S_DONE;
      end
      S_POP:  state_d = sts_i.q_empty ? S_DONE : S_LOAD;
      S_LOAD: state_d = S_CNT;
      S_CNT:  state_d = sts_i.ec_zero ? S_DONE : S_EDGE;
      S_EDGE: begin
        if (sts_i.t_bad) begin
          state_d = S_DONE;
        end else if (sts_i.scan_last) begin
          state_d = S_POP;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: cmd_o.latch_in = in_valid_i;
      S_EXEC: begin
        case (sts_i.op)
          OP_CLEAR: begin
            cmd_o.do_clear = 1'b1;
            cmd_o.res_load = 1'b1;
          end
          OP_ADD_NODE: begin
            cmd_o.res_load = 1'b1;
            if (sts_i.node_full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.do_add_node = 1'b1;
            end
          end
          OP_ADD_EDGE: begin
            if (sts_i.bad_index) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_BAD_INDEX;
            end else if (sts_i.list_full) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EDGES_FULL;
            end else if (sts_i.ec_zero) begin
              cmd_o.do_edge_write = 1'b1;
              cmd_o.res_load      = 1'b1;
            end else begin
              cmd_o.ek_clr = 1'b1;
            end
          end
          OP_VALIDATE: begin
            if (sts_i.no_nodes) begin
              cmd_o.path_we    = 1'b1;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INVALID;
            end else begin
              cmd_o.walk_init = 1'b1;
            end
          end
          default: cmd_o.res_load = 1'b0;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_DUPLICATE;
        end else if (sts_i.scan_last) begin
          cmd_o.do_edge_write = 1'b1;
          cmd_o.res_load      = 1'b1;
        end else begin
          cmd_o.ek_inc = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.walk_sel = 1'b1;
        if (sts_i.q_empty) begin
          // every reached node was enqueued once, so tail counts the visited set
          cmd_o.path_we    = 1'b1;
          cmd_o.path_val   = sts_i.all_reached;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = sts_i.all_reached ? ST_OK : ST_INVALID;
        end else begin
          cmd_o.q_pop = 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.walk_sel = 1'b1;
        cmd_o.cur_load = 1'b1;
      end
      S_CNT: begin
        cmd_o.walk_sel = 1'b1;
        if (sts_i.ec_zero) begin
          cmd_o.path_we    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INVALID;
        end else begin
          cmd_o.ek_clr = 1'b1;
        end
      end
      S_EDGE: begin
        cmd_o.walk_sel = 1'b1;
        if (sts_i.t_bad) begin
          cmd_o.path_we    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INVALID;
        end else begin
          cmd_o.walk_visit = 1'b1;
          cmd_o.ek_inc     = !sts_i.scan_last;
        end
      end
      S_DONE:  cmd_o.out_load = out_free;
      default: cmd_o.latch_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/directed_graph_reachability_checker_core.sv =====
// Directed graph reachability checker.
// Request channel (in_valid_i/in_ready_o): opcode_i, source_node_i, target_node_i.
// Response channel (out_valid_o/out_ready_i): status_o, node_index_o, graph_valid_o;
// one response per request, in request order.
// Work from request accept to response valid:
//   clear, add node, rejected add edge, validate with no nodes: no scan or walk.
//   add edge: the duplicate scan reads one target a cycle from the edge-target
//   RAM over the edges already on the source node and stops early on a hit.
//   validate: the walk pops one node from the queue RAM, then checks one edge
//   a cycle; it stops early when it fails.
// One request is in flight at a time; a new request is taken as soon as the
// previous response sits in the output register, even if not yet taken.
// If the receiver stalls, the response holds and a following request runs
// to completion then waits in the controller until the output frees.
// Reset empties the graph (no nodes, all edge counts zero, valid flag low);
// no clearing pass is needed.
`default_nettype none

module directed_graph_reachability_checker_core #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned MAX_EDGES = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [dgrc_pkg::OP_W-1:0] opcode_i,
  input  wire logic [dgrc_pkg::NI_W-1:0] source_node_i,
  input  wire logic [dgrc_pkg::NI_W-1:0] target_node_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [dgrc_pkg::ST_W-1:0] status_o,
  output logic      [dgrc_pkg::NI_W-1:0] node_index_o,
  output logic                           graph_valid_o
);
  import dgrc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dgrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dgrc_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .source_node_i (source_node_i),
    .target_node_i (target_node_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .node_index_o  (node_index_o),
    .graph_valid_o (graph_valid_o)
  );

endmodule

`default_nettype wire
